>>> design/bfa_pkg.sv
`default_nettype none

package bfa_pkg;

  localparam int unsigned BCD_DIGITS = 9;

  typedef logic [3:0] bcd_digit_t;
  typedef logic [BCD_DIGITS*4-1:0] bcd_value_t;
  typedef logic [2:0] frame_pos_t;
  typedef logic [3:0] char_idx_t;
  typedef logic [6:0] ascii_t;

  localparam frame_pos_t FRAME_MODE_POS = 3'd4;

  localparam char_idx_t IDX_F           = 4'd0;
  localparam char_idx_t IDX_A           = 4'd1;
  localparam char_idx_t IDX_PAD         = 4'd2;
  localparam char_idx_t IDX_DIGIT_FIRST = 4'd3;
  localparam char_idx_t IDX_DIGIT_LAST  = 4'd11;
  localparam char_idx_t IDX_TAIL_ZERO   = 4'd12;
  localparam char_idx_t IDX_SEMI        = 4'd13;

  localparam ascii_t CHAR_F    = 7'h46;
  localparam ascii_t CHAR_A    = 7'h41;
  localparam ascii_t CHAR_ZERO = 7'h30;
  localparam ascii_t CHAR_SEMI = 7'h3B;

endpackage

`default_nettype wire

>>> design/bfa_in_if.sv
`default_nettype none

interface bfa_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface bfa_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] tx_char;
  logic       last_char;

  modport source (output valid, output tx_char, output last_char, input ready);
  modport sink   (input valid, input tx_char, input last_char, output ready);
endinterface

`default_nettype wire

>>> design/bcd_freq_frame_to_ascii_cmd_unit.sv
`default_nettype none

// Channel | Dir | Payload                  | Transaction
// req     | in  | action[0], rx_byte[7:0]  | one received byte or a resync
// cmd     | out | tx_char[6:0], last_char  | one command character
//
// Data bytes and resyncs are accepted every cycle, except at the mode position.
// The mode byte starts a 14-character burst;
// the value is kept in BCD, so each character is a nibble select with no
// conversion step. At the mode position any byte (mode byte or resync) waits
// while a previous burst is still sending; it goes in on the edge that sends ';'.
// cmd stalls hold the current character; rst (synchronous) clears framing.
module bcd_freq_frame_to_ascii_cmd_unit
  import bfa_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  bfa_in_if.sink     req,
  bfa_out_if.source  cmd
);

  frame_pos_t frame_position, frame_position_next;
  bcd_value_t running_value, running_value_next;
  logic       emit_busy, emit_busy_next;
  char_idx_t  emit_idx, emit_idx_next;
  bcd_value_t emit_digits, emit_digits_next;

  logic req_fire, cmd_fire, is_mode_pos, emit_done;

  // Byte weight hi*10+lo split into hundreds/tens/ones (nibbles up to 15).
  bcd_digit_t hi_nib, lo_nib, ones, tens;
  logic       lo_carry, hund;
  logic [4:0] tens_raw;
  bcd_value_t accum;
  logic       carry;

  assign is_mode_pos = (frame_position >= FRAME_MODE_POS);
  assign emit_done   = cmd_fire && (emit_idx == IDX_SEMI);
  assign req.ready   = !is_mode_pos || !emit_busy || emit_done;
  assign req_fire    = req.valid && req.ready;
  assign cmd_fire    = cmd.valid && cmd.ready;

  always_comb begin
    hi_nib   = req.rx_byte[7:4];
    lo_nib   = req.rx_byte[3:0];
    lo_carry = (lo_nib >= 4'd10);
    ones     = lo_carry ? 4'(lo_nib - 4'd10) : lo_nib;
    tens_raw = {1'b0, hi_nib} + {4'd0, lo_carry};
    hund     = (tens_raw >= 5'd10);
    tens     = hund ? 4'(tens_raw - 5'd10) : tens_raw[3:0];
    // shift two decimal places, insert tens/ones, ripple the hundreds carry
    accum        = '0;
    accum[3:0]   = ones;
    accum[7:4]   = tens;
    carry        = hund;
    for (int i = 2; i < BCD_DIGITS; i++) begin
      if (carry && (running_value[(i-2)*4 +: 4] == 4'd9)) begin
        accum[i*4 +: 4] = 4'd0;
      end else begin
        accum[i*4 +: 4] = 4'(running_value[(i-2)*4 +: 4] + {3'd0, carry});
        carry = 1'b0;
      end
    end
  end

  always_comb begin
    frame_position_next = frame_position;
    running_value_next  = running_value;
    emit_busy_next      = emit_busy;
    emit_idx_next       = emit_idx;
    emit_digits_next    = emit_digits;

    if (cmd_fire) begin
      emit_idx_next = 4'(emit_idx + 4'd1);
      if (emit_idx >= IDX_DIGIT_FIRST && emit_idx <= IDX_DIGIT_LAST) begin
        emit_digits_next = {emit_digits[BCD_DIGITS*4-5:0], 4'd0};
      end
      if (emit_idx == IDX_SEMI) begin
        emit_busy_next = 1'b0;
      end
    end

    if (req_fire) begin
      if (req.action) begin
        frame_position_next = '0;
        running_value_next  = '0;
      end else if (!is_mode_pos) begin
        running_value_next  = accum;
        frame_position_next = 3'(frame_position + 3'd1);
      end else begin
        // load the burst; this wins over the final character's completion
        emit_busy_next      = 1'b1;
        emit_idx_next       = IDX_F;
        emit_digits_next    = running_value;
        frame_position_next = '0;
        running_value_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      running_value  <= '0;
      emit_busy      <= 1'b0;
      emit_idx       <= IDX_F;
    end else begin
      frame_position <= frame_position_next;
      running_value  <= running_value_next;
      emit_busy      <= emit_busy_next;
      emit_idx       <= emit_idx_next;
    end
    emit_digits <= emit_digits_next;
  end

  assign cmd.valid     = emit_busy;
  assign cmd.last_char = (emit_idx == IDX_SEMI);

  always_comb begin
    case (emit_idx)
      IDX_F:         cmd.tx_char = CHAR_F;
      IDX_A:         cmd.tx_char = CHAR_A;
      IDX_PAD:       cmd.tx_char = CHAR_ZERO;
      IDX_TAIL_ZERO: cmd.tx_char = CHAR_ZERO;
      IDX_SEMI:      cmd.tx_char = CHAR_SEMI;
      default:       cmd.tx_char = CHAR_ZERO | {3'd0, emit_digits[BCD_DIGITS*4-1 -: 4]};
    endcase
  end

endmodule

`default_nettype wire
